@@ hdl/pcxrle_pkg.sv @@
// Shared types and constants of the PCX run-length decoder.
`timescale 1ns / 1ps
`default_nettype none
package pcxrle_pkg;

  // Register indexes on the configuration port.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_LINE_BYTES = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LINE_COUNT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ROW_STRIDE = 2'd2;

  // Register reset values.
  localparam logic [11:0] BPL_RESET    = 12'd320;
  localparam logic [11:0] LINES_RESET  = 12'd200;
  localparam logic [15:0] STRIDE_RESET = 16'd320;

  // Run header marker and count mask.
  localparam logic [1:0] RUN_MARK  = 2'b11;
  localparam logic [7:0] RUN_MASK  = 8'h3f;

  // Default depth of the command queue between front and back.
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // One command for the back end: a pixel value and how often to write it.
  typedef struct packed {
    logic [7:0] pixel;
    logic [5:0] count;
  } cmd_t;

  // Picture geometry as seen by the back end.
  typedef struct packed {
    logic [11:0] line_bytes;
    logic [11:0] line_count;
    logic [15:0] row_stride;
  } geom_t;

endpackage
`default_nettype wire

@@ hdl/pcxrle_front.sv @@
// Front end: takes code bytes, tracks run headers and issues pixel commands.
`timescale 1ns / 1ps
`default_nettype none
module pcxrle_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_byte,
  output logic                   push,
  output pcxrle_pkg::cmd_t       push_cmd,
  input  wire logic              q_full
);

  logic       pending_r, pending_nxt;
  logic [5:0] count_r, count_nxt;
  logic       accept;
  logic       is_mark;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_mark  = (in_byte[7:6] == pcxrle_pkg::RUN_MARK);

  // Classify the byte: run header, run data or literal.
  always_comb begin
    pending_nxt    = pending_r;
    count_nxt      = count_r;
    push           = 1'b0;
    push_cmd.pixel = in_byte;
    push_cmd.count = 6'd1;
    if (accept) begin
      if (pending_r) begin
        push_cmd.count = count_r;
        push           = (count_r != 6'd0);
        pending_nxt    = 1'b0;
        count_nxt      = 6'd0;
      end else if (is_mark) begin
        pending_nxt = 1'b1;
        count_nxt   = 6'(in_byte & pcxrle_pkg::RUN_MASK);
      end else begin
        push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      count_r   <= 6'd0;
    end else begin
      pending_r <= pending_nxt;
      count_r   <= count_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hdl/pcxrle_queue.sv @@
// Small command queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module pcxrle_queue #(
  parameter int unsigned DEPTH = pcxrle_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  pcxrle_pkg::cmd_t       push_cmd,
  output logic                   full,
  input  wire logic              pop,
  output pcxrle_pkg::cmd_t       pop_cmd,
  output logic                   not_empty
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);

  pcxrle_pkg::cmd_t      slot_r [DEPTH];
  logic [PtrW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]       fill_r, fill_nxt;
  logic                  do_push;
  logic                  do_pop;

  assign full      = (fill_r == CntW'(DEPTH));
  assign not_empty = (fill_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_cmd   = slot_r[rd_ptr_r];

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

@@ hdl/pcxrle_back.sv @@
// Back end: expands commands into addressed pixels and tracks rows.
`timescale 1ns / 1ps
`default_nettype none
module pcxrle_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  pcxrle_pkg::geom_t      geom,
  input  wire logic              q_not_empty,
  input  pcxrle_pkg::cmd_t       q_cmd,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             out_pixel,
  output logic [15:0]            out_address,
  output logic                   out_last,
  output logic                   out_row_done,
  output logic                   out_image_done
);

  // Current command.
  logic        active_r, active_nxt;
  logic [5:0]  count_r, count_nxt;
  logic [7:0]  pix_r, pix_nxt;
  // Position in the picture.
  logic [15:0] column_r, column_nxt;
  logic [11:0] row_r, row_nxt;
  logic [15:0] base_r, base_nxt;
  // Output register.
  logic        ovalid_r, ovalid_nxt;
  logic [7:0]  opix_r, opix_nxt;
  logic [15:0] oaddr_r, oaddr_nxt;
  logic        olast_r, olast_nxt;
  logic        orow_r, orow_nxt;
  logic        oimg_r, oimg_nxt;

  logic        fire;
  logic        is_last;
  logic [15:0] col_inc;
  logic        row_end;
  logic        img_end;

  assign fire    = active_r && (!ovalid_r || out_ready);
  assign is_last = (count_r == 6'd1);
  assign q_pop   = q_not_empty && (!active_r || (fire && is_last));
  assign col_inc = column_r + 16'd1;
  // A row length of zero behaves as one, since col_inc is never below one.
  assign row_end = (col_inc >= {4'd0, geom.line_bytes});
  assign img_end = ({1'b0, row_r} + 13'd1 >= {1'b0, geom.line_count});

  // Emit one pixel per cycle while the output register can take it, and advance the position counters.
  always_comb begin
    active_nxt = active_r;
    count_nxt  = count_r;
    pix_nxt    = pix_r;
    column_nxt = column_r;
    row_nxt    = row_r;
    base_nxt   = base_r;
    ovalid_nxt = ovalid_r && !out_ready;
    opix_nxt   = opix_r;
    oaddr_nxt  = oaddr_r;
    olast_nxt  = olast_r;
    orow_nxt   = orow_r;
    oimg_nxt   = oimg_r;

    if (fire) begin
      ovalid_nxt = 1'b1;
      opix_nxt   = pix_r;
      oaddr_nxt  = base_r + column_r;
      olast_nxt  = is_last;
      orow_nxt   = is_last && row_end;
      oimg_nxt   = is_last && row_end && img_end;
      count_nxt  = count_r - 6'd1;
      column_nxt = col_inc;
      if (is_last) begin
        active_nxt = 1'b0;
        if (row_end) begin
          column_nxt = 16'd0;
          if (img_end) begin
            row_nxt  = 12'd0;
            base_nxt = 16'd0;
          end else begin
            row_nxt  = row_r + 12'd1;
            base_nxt = base_r + geom.row_stride;
          end
        end
      end
    end

    // Load the next command as the current one finishes, or when no command is active.
    if (q_pop) begin
      active_nxt = 1'b1;
      count_nxt  = q_cmd.count;
      pix_nxt    = q_cmd.pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      count_r  <= 6'd0;
      column_r <= 16'd0;
      row_r    <= 12'd0;
      base_r   <= 16'd0;
      ovalid_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      count_r  <= count_nxt;
      column_r <= column_nxt;
      row_r    <= row_nxt;
      base_r   <= base_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_r   <= pix_nxt;
    opix_r  <= opix_nxt;
    oaddr_r <= oaddr_nxt;
    olast_r <= olast_nxt;
    orow_r  <= orow_nxt;
    oimg_r  <= oimg_nxt;
  end

  assign out_valid      = ovalid_r;
  assign out_pixel      = opix_r;
  assign out_address    = oaddr_r;
  assign out_last       = olast_r;
  assign out_row_done   = orow_r;
  assign out_image_done = oimg_r;

endmodule
`default_nettype wire

@@ hdl/pcx_rle_decoder.sv @@
// Top level of the PCX run-length decoder.
//
//   Channel | Direction | Payload
//   --------+-----------+---------------------------------------------------
//   in_     | in        | tdata[7:0] code_byte
//   out_    | out       | tdata pixel/address, tlast last, tuser row/image done
//   cfg_    | in        | addr = register index, wdata = register value
//
// A literal byte or run data byte is taken each cycle while the command queue
// has room; a run header is taken the same way but gives no pixel. The back end
// writes one pixel per cycle while the output is not stalled.
// The queue lets code bytes keep arriving while a run expands. Output stalls
// hold the output register and back up through the queue to in_tready.
// Reset (synchronous, active low) empties the queue and zeroes all counters.
`timescale 1ns / 1ps
`default_nettype none
module pcx_rle_decoder #(
  parameter int unsigned QUEUE_DEPTH = pcxrle_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [7:0]                        in_tdata,   // [7:0] code_byte
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [23:0]                            out_tdata,  // [7:0] pixel, [23:8] address
  output logic                                   out_tlast,
  output logic [1:0]                             out_tuser,  // [0] row_done, [1] image_done
  input  wire logic                              cfg_we,
  input  wire logic [pcxrle_pkg::CfgIdxW-1:0]    cfg_addr,
  input  wire logic [15:0]                       cfg_wdata
);

  pcxrle_pkg::geom_t geom_r, geom_nxt;
  pcxrle_pkg::cmd_t  push_cmd;
  pcxrle_pkg::cmd_t  pop_cmd;
  logic              push;
  logic              q_full;
  logic              q_pop;
  logic              q_not_empty;
  logic [7:0]        pix;
  logic [15:0]       addr;
  logic              row_done;
  logic              image_done;

  // Configuration registers.
  always_comb begin
    geom_nxt = geom_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        pcxrle_pkg::CFG_LINE_BYTES: geom_nxt.line_bytes = cfg_wdata[11:0];
        pcxrle_pkg::CFG_LINE_COUNT: geom_nxt.line_count = cfg_wdata[11:0];
        pcxrle_pkg::CFG_ROW_STRIDE: geom_nxt.row_stride = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geom_r.line_bytes <= pcxrle_pkg::BPL_RESET;
      geom_r.line_count <= pcxrle_pkg::LINES_RESET;
      geom_r.row_stride <= pcxrle_pkg::STRIDE_RESET;
    end else begin
      geom_r <= geom_nxt;
    end
  end

  pcxrle_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full)
  );

  pcxrle_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_cmd   (pop_cmd),
    .not_empty (q_not_empty)
  );

  pcxrle_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .geom           (geom_r),
    .q_not_empty    (q_not_empty),
    .q_cmd          (pop_cmd),
    .q_pop          (q_pop),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_pixel      (pix),
    .out_address    (addr),
    .out_last       (out_tlast),
    .out_row_done   (row_done),
    .out_image_done (image_done)
  );

  assign out_tdata = {addr, pix};
  assign out_tuser = {image_done, row_done};

endmodule
`default_nettype wire

@@ sim/tb_pcx_rle_decoder.sv @@
// Testbench for the PCX run-length decoder: code byte streams checked against a pixel predictor.
`timescale 1ns / 1ps
module tb_pcx_rle_decoder;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned IdlePercent  = 19;
  localparam int unsigned ReportMax    = 10;

  // One decoded pixel as it leaves the block.
  typedef struct packed {
    logic [7:0]  pixel;
    logic [15:0] address;
    logic        last;
    logic        row_done;
    logic        image_done;
  } pixel_t;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [7:0]                      in_tdata   = '0;   // [7:0] code_byte
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [23:0]                     out_tdata;         // [7:0] pixel, [23:8] address
  logic                            out_tlast;
  logic [1:0]                      out_tuser;         // [0] row_done, [1] image_done
  logic                            cfg_we     = 1'b0;
  logic [pcxrle_pkg::CfgIdxW-1:0]  cfg_addr   = '0;
  logic [15:0]                     cfg_wdata  = '0;

  pcx_rle_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Code bytes waiting to be sent and pixels waiting to come back.
  logic [7:0]  code_q[$];
  pixel_t      pixel_q[$];
  bit          calm       = 1'b0;
  int unsigned mismatches = 0;
  int unsigned cycles     = 0;

  // Decoder state and geometry as the predictor tracks them.
  logic [11:0] line_len;
  logic [11:0] line_total;
  logic [15:0] stride;
  logic        run_armed;
  logic [5:0]  run_len;
  logic [15:0] col;
  logic [11:0] row;
  logic [15:0] base;

  initial begin
    forever #6 clk = ~clk;
  end

  // Work out the pixels that one accepted code byte produces.
  task automatic decode_byte(input logic [7:0] code);
    int unsigned n;
    int unsigned k;
    logic [15:0] col_end;
    logic        row_end;
    logic        img_end;
    pixel_t      p;
    if (run_armed) begin
      n = run_len;
      run_armed = 1'b0;
      run_len = '0;
    end else if (code[7:6] == pcxrle_pkg::RUN_MARK) begin
      run_armed = 1'b1;
      run_len = code[5:0];
      return;
    end else begin
      n = 1;
    end
    // A zero count swallows the data byte without touching the counters.
    if (n == 0) return;
    col_end = col + 16'(n);
    row_end = (col_end >= {4'd0, line_len});
    img_end = row_end && (({1'b0, row} + 13'd1) >= {1'b0, line_total});
    for (k = 0; k < n; k++) begin
      p.pixel      = code;
      p.address    = base + col;
      p.last       = (k == n - 1);
      p.row_done   = p.last && row_end;
      p.image_done = p.last && img_end;
      pixel_q.push_back(p);
      col = col + 16'd1;
    end
    if (row_end) begin
      col = '0;
      if (img_end) begin
        row  = '0;
        base = '0;
      end else begin
        row  = row + 12'd1;
        base = base + stride;
      end
    end
  endtask

  // Write all three geometry registers while the block is idle.
  task automatic write_geometry(input logic [11:0] bpl, input logic [11:0] lines,
                                input logic [15:0] row_gap);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= pcxrle_pkg::CFG_LINE_BYTES;
    cfg_wdata <= {4'd0, bpl};
    @(posedge clk);
    cfg_addr  <= pcxrle_pkg::CFG_LINE_COUNT;
    cfg_wdata <= {4'd0, lines};
    @(posedge clk);
    cfg_addr  <= pcxrle_pkg::CFG_ROW_STRIDE;
    cfg_wdata <= row_gap;
    @(posedge clk);
    cfg_we    <= 1'b0;
    line_len   = bpl;
    line_total = lines;
    stride     = row_gap;
  endtask

  // Hold off until every request has gone in and every pixel has come back.
  // The check runs at the falling edge, when the sender and monitor have settled.
  task automatic drain();
    while (code_q.size() != 0 || in_tvalid || pixel_q.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Mostly literals and well-formed runs, with some raw bytes mixed in.
  task automatic queue_stream(input int unsigned count);
    int unsigned made;
    int unsigned pick;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        code_q.push_back(8'($urandom_range(0, 191)));
        made++;
      end else if (pick < 88) begin
        code_q.push_back({pcxrle_pkg::RUN_MARK, 6'($urandom_range(0, 63))});
        code_q.push_back(8'($urandom_range(0, 255)));
        made += 2;
      end else begin
        code_q.push_back(8'($urandom));
        made++;
      end
    end
  endtask

  // Sender: takes the next code byte once the current request is gone.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (code_q.size() != 0 && (calm || $urandom_range(0, 99) >= IdlePercent)) begin
        in_tvalid <= 1'b1;
        in_tdata  <= code_q.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(0, 99) >= IdlePercent);
  end

  // Predict on accepted code bytes and check each accepted pixel.
  always @(posedge clk) begin : monitor
    pixel_t want;
    pixel_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) decode_byte(in_tdata);
      if (out_tvalid && out_tready) begin
        got = {out_tdata[7:0], out_tdata[23:8], out_tlast, out_tuser[0], out_tuser[1]};
        if (pixel_q.size() == 0) begin
          if (mismatches < ReportMax)
            $display("unexpected pixel %h at address %h", got.pixel, got.address);
          mismatches++;
        end else begin
          want = pixel_q.pop_front();
          if (got !== want) begin
            if (mismatches < ReportMax)
              $display("pixel mismatch: expected %h @%h l%b r%b i%b, got %h @%h l%b r%b i%b",
                       want.pixel, want.address, want.last, want.row_done, want.image_done,
                       got.pixel, got.address, got.last, got.row_done, got.image_done);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb_pcx_rle_decoder NOT OK");
      $finish;
    end
  end

  initial begin
    line_len   = 12'd320;
    line_total = 12'd200;
    stride     = 16'd320;
    run_armed  = 1'b0;
    run_len    = '0;
    col        = '0;
    row        = '0;
    base       = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset geometry: literal extremes, an empty run, a full run of a marker-like
    // value, and a run whose data byte looks like a run header.
    code_q = '{8'h00, 8'hbf, 8'h7f, 8'h40, 8'h80, 8'hc0, 8'h55, 8'hff, 8'hff,
               8'hc1, 8'hc3, 8'hc5, 8'h00, 8'h3f};
    drain();

    // Zero row length and zero row count: each pixel-giving byte ends the picture.
    write_geometry(12'd0, 12'd0, 16'hffff);
    code_q = '{8'h12, 8'hc3, 8'hed, 8'hc0, 8'h01, 8'h01};
    drain();

    // Largest geometry; the phase ends with a run header still waiting for data.
    write_geometry(12'd4095, 12'd4095, 16'hffff);
    code_q = '{8'hff, 8'ha5, 8'h5a, 8'hc4};
    drain();

    // Random streams over a range of geometries.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_geometry(12'd1, 12'd1, 16'd0);
        3: write_geometry(12'($urandom_range(2, 12)), 12'd4095, 16'hfff0);
        5: write_geometry(12'd320, 12'd200, 16'd320);
        default: write_geometry(12'($urandom_range(1, 48)), 12'($urandom_range(1, 6)),
                                16'($urandom));
      endcase
      calm = (ph == 2);
      queue_stream(31);
      drain();
    end

    if (mismatches == 0) begin
      $display("tb_pcx_rle_decoder OK");
    end else begin
      $display("tb_pcx_rle_decoder NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/pcxrle_pkg.sv
hdl/pcxrle_front.sv
hdl/pcxrle_queue.sv
hdl/pcxrle_back.sv
hdl/pcx_rle_decoder.sv
sim/tb_pcx_rle_decoder.sv
